@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL files of the PPPoE tag extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/pte_pkg.sv @@
// Package with the types and codes of the PPPoE tag extractor.
package pte_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TAG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COPY_LIMIT = 1'd1;

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FOUND     = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;

    // Byte positions of the PPPoE length field.
    localparam logic [WORD_W-1:0] POS_LEN_HI = 16'd18;
    localparam logic [WORD_W-1:0] POS_LEN_LO = 16'd19;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_TYPE_HI,
        PH_TYPE_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_SKIP,
        PH_COPY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_end;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WORD_W-1:0] out_value;
        logic              run_last;
    } t_out;

endpackage

@@ rtl/core/pte_parser.sv @@
// Per-byte parser of the PPPoE header and tag list.
`include "assert_macros.svh"

module pte_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  pte_pkg::t_in                  i_data,
    input  logic [pte_pkg::WORD_W-1:0]    i_wanted_tag,
    input  logic [pte_pkg::WORD_W-1:0]    i_copy_limit,
    output logic                          o_res_valid,
    output pte_pkg::t_out                 o_res
);

    pte_pkg::t_phase               r_phase, n_phase;
    logic [pte_pkg::WORD_W-1:0]    r_pos, n_pos;
    logic [pte_pkg::WORD_W-1:0]    r_pay_len, n_pay_len;
    logic [pte_pkg::BYTE_W-1:0]    r_acc_hi, n_acc_hi;
    logic                          r_tag_match, n_tag_match;
    logic [pte_pkg::WORD_W-1:0]    r_skip_left, n_skip_left;
    logic [pte_pkg::WORD_W-1:0]    r_copy_left, n_copy_left;

    logic [pte_pkg::WORD_W-1:0]    field;
    logic [pte_pkg::WORD_W-1:0]    skip_dec;
    logic [pte_pkg::WORD_W-1:0]    copy_dec;
    logic [pte_pkg::WORD_W-1:0]    copy_len;
    logic                          list_end;
    logic                          res_v;
    logic                          res_last;
    logic [1:0]                    res_kind;
    logic [pte_pkg::WORD_W-1:0]    res_val;

    assign field    = {r_acc_hi, i_data.frame_byte};
    assign skip_dec = r_skip_left - 16'd1;
    assign copy_dec = r_copy_left - 16'd1;
    assign copy_len = (field < i_copy_limit) ? field : i_copy_limit;
    // Tag phases only run from byte 20 on, so pos - 19 cannot wrap.
    assign list_end = (r_pos - pte_pkg::POS_LEN_LO) >= r_pay_len;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = (r_pos != '1) ? r_pos + 16'd1 : r_pos;
        n_pay_len   = r_pay_len;
        n_acc_hi    = r_acc_hi;
        n_tag_match = r_tag_match;
        n_skip_left = r_skip_left;
        n_copy_left = r_copy_left;
        res_v       = 1'b0;
        res_last    = 1'b0;
        res_kind    = pte_pkg::KIND_NOT_FOUND;
        res_val     = '0;

        unique case (r_phase)
            pte_pkg::PH_HEADER: begin
                if (r_pos == pte_pkg::POS_LEN_HI) begin
                    n_acc_hi = i_data.frame_byte;
                end else if (r_pos == pte_pkg::POS_LEN_LO) begin
                    n_pay_len = field;
                    if (field == '0) begin
                        res_v    = 1'b1;
                        res_last = 1'b1;
                    end else begin
                        n_phase = pte_pkg::PH_TYPE_HI;
                    end
                end
            end
            pte_pkg::PH_TYPE_HI: begin
                n_acc_hi = i_data.frame_byte;
                n_phase  = pte_pkg::PH_TYPE_LO;
            end
            pte_pkg::PH_TYPE_LO: begin
                n_tag_match = (field == i_wanted_tag);
                n_phase     = pte_pkg::PH_LEN_HI;
            end
            pte_pkg::PH_LEN_HI: begin
                n_acc_hi = i_data.frame_byte;
                n_phase  = pte_pkg::PH_LEN_LO;
            end
            pte_pkg::PH_LEN_LO: begin
                if (r_tag_match) begin
                    n_copy_left = copy_len;
                    res_v       = 1'b1;
                    res_kind    = pte_pkg::KIND_FOUND;
                    res_val     = field;
                    if (copy_len == '0) begin
                        res_last = 1'b1;
                    end else begin
                        n_phase = pte_pkg::PH_COPY;
                    end
                end else if (field == '0) begin
                    if (list_end) begin
                        res_v    = 1'b1;
                        res_last = 1'b1;
                    end else begin
                        n_phase = pte_pkg::PH_TYPE_HI;
                    end
                end else begin
                    n_skip_left = field;
                    n_phase     = pte_pkg::PH_SKIP;
                end
            end
            pte_pkg::PH_SKIP: begin
                n_skip_left = skip_dec;
                if (skip_dec == '0) begin
                    if (list_end) begin
                        res_v    = 1'b1;
                        res_last = 1'b1;
                    end else begin
                        n_phase = pte_pkg::PH_TYPE_HI;
                    end
                end
            end
            pte_pkg::PH_COPY: begin
                n_copy_left = copy_dec;
                res_v       = 1'b1;
                res_kind    = pte_pkg::KIND_DATA;
                res_val     = {8'd0, i_data.frame_byte};
                res_last    = (copy_dec == '0);
            end
            pte_pkg::PH_DONE: begin
            end
            default: begin
            end
        endcase

        // A frame that ends before its answer closes with not-found.
        if (i_data.frame_end && r_phase != pte_pkg::PH_DONE) begin
            if (!res_v) begin
                res_v    = 1'b1;
                res_kind = pte_pkg::KIND_NOT_FOUND;
                res_val  = '0;
            end
            res_last = 1'b1;
        end

        if (res_v && res_last) begin
            n_phase = pte_pkg::PH_DONE;
        end

        if (i_data.frame_end) begin
            n_phase     = pte_pkg::PH_HEADER;
            n_pos       = '0;
            n_pay_len   = '0;
            n_acc_hi    = '0;
            n_tag_match = 1'b0;
            n_skip_left = '0;
            n_copy_left = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= pte_pkg::PH_HEADER;
            r_pos       <= '0;
            r_pay_len   <= '0;
            r_acc_hi    <= '0;
            r_tag_match <= 1'b0;
            r_skip_left <= '0;
            r_copy_left <= '0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_pay_len   <= n_pay_len;
            r_acc_hi    <= n_acc_hi;
            r_tag_match <= n_tag_match;
            r_skip_left <= n_skip_left;
            r_copy_left <= n_copy_left;
        end
    end

    assign o_res_valid     = i_valid && res_v;
    assign o_res.kind      = res_kind;
    assign o_res.out_value = res_val;
    assign o_res.run_last  = res_last;

    `ASSERT_SAME(a_done_silent, i_clk, i_rst_n, i_valid && r_phase == pte_pkg::PH_DONE, !o_res_valid)
    `ASSERT_SAME(a_end_answers, i_clk, i_rst_n,
        i_valid && i_data.frame_end && r_phase != pte_pkg::PH_DONE, o_res_valid && o_res.run_last)
    `ASSERT_NEXT(a_last_closes, i_clk, i_rst_n,
        o_res_valid && o_res.run_last, r_phase == pte_pkg::PH_DONE || r_phase == pte_pkg::PH_HEADER)

endmodule

@@ rtl/core/pppoe_tag_extractor_unit.sv @@
// Top level of the PPPoE tag extractor: configuration, parser and output skid stage.
//
// Frames enter one byte per transaction on the input channel (i_valid, o_stall,
// i_data), starting at the destination MAC, with frame_end set on the last byte.
// The unit finds the first tag whose type equals wanted_tag in the PPPoE payload
// and answers with one found transaction carrying the tag length, followed by up
// to copy_limit data-byte transactions; otherwise it answers with one not-found
// transaction. run_last marks the final result transaction of a frame.
// Results of an accepted byte are registered in the output stage and leave on the
// output channel (o_valid, i_stall, o_data). One byte is accepted every cycle
// while o_stall is low; the parser updates its counters in the cycle of acceptance.
// A two-entry output stage (result register plus skid register) absorbs a stall:
// the byte at a stalled edge is still accepted, and o_stall rises only when both
// entries are full, then holds the input until the output is no longer stalled.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
// next edge; the user must make them while no frame is open, the block does not
// enforce it. Synchronous reset clears both registers to zero, empties the output
// stage and puts the parser at the start of a frame.
`include "assert_macros.svh"

module pppoe_tag_extractor_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  pte_pkg::t_in                    i_data,
    output logic                            o_valid,
    input  logic                            i_stall,
    output pte_pkg::t_out                   o_data,
    input  logic                            i_cfg_we,
    input  logic [pte_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pte_pkg::WORD_W-1:0]      i_cfg_data
);

    logic [pte_pkg::WORD_W-1:0] r_wanted_tag;
    logic [pte_pkg::WORD_W-1:0] r_copy_limit;
    logic                       r_out_valid;
    pte_pkg::t_out              r_out;
    logic                       r_skid_valid;
    pte_pkg::t_out              r_skid;

    logic                       accept;
    logic                       res_valid;
    pte_pkg::t_out              res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_tag <= '0;
            r_copy_limit <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pte_pkg::CFG_WANTED_TAG: r_wanted_tag <= i_cfg_data;
                pte_pkg::CFG_COPY_LIMIT: r_copy_limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept = i_valid && !r_skid_valid;

    pte_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_data       (i_data),
        .i_wanted_tag (r_wanted_tag),
        .i_copy_limit (r_copy_limit),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            // The skid entry is older than anything arriving now.
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_SAME(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `ASSERT_SAME(a_no_result_when_full, i_clk, i_rst_n, r_skid_valid, !res_valid)
    `ASSERT_NEXT(a_skid_fills, i_clk, i_rst_n,
        r_out_valid && i_stall && res_valid, r_skid_valid && r_out_valid)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the PPPoE tag extractor: directed and random frames with a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 100;
    localparam int NUM_PHASES  = 8;

    // Predicts the results of the tag search and holds them until they are checked.
    class tag_scoreboard;
        logic [pte_pkg::WORD_W-1:0] wanted_tag;
        logic [pte_pkg::WORD_W-1:0] copy_limit;
        logic [pte_pkg::WORD_W-1:0] byte_pos;
        logic [pte_pkg::WORD_W-1:0] pay_len;
        logic [pte_pkg::WORD_W-1:0] field_acc;
        logic [pte_pkg::WORD_W-1:0] tag_type;
        logic [pte_pkg::WORD_W-1:0] skip_left;
        logic [pte_pkg::WORD_W-1:0] copy_left;
        pte_pkg::t_phase            phase;
        pte_pkg::t_out              answer_q[$];
        int unsigned                n_found;
        int unsigned                n_not_found;
        int unsigned                n_data;
        int unsigned                n_errors;

        function new();
            wanted_tag  = '0;
            copy_limit  = '0;
            n_found     = 0;
            n_not_found = 0;
            n_data      = 0;
            n_errors    = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            pay_len   = '0;
            field_acc = '0;
            tag_type  = '0;
            skip_left = '0;
            copy_left = '0;
            phase     = pte_pkg::PH_HEADER;
        endfunction

        // True when the next tag would start at or past the end of the payload.
        function bit list_over();
            int unsigned next_off;
            next_off = ({16'd0, byte_pos} + 32'd1) - 32'd20;
            return next_off >= {16'd0, pay_len};
        endfunction

        function void note_input(pte_pkg::t_in item);
            logic [pte_pkg::BYTE_W-1:0] b;
            logic [pte_pkg::WORD_W-1:0] tlen;
            logic [1:0]                 kind;
            logic [pte_pkg::WORD_W-1:0] val;
            bit                         hit;
            bit                         last;
            bit                         was_done;
            b        = item.frame_byte;
            was_done = (phase == pte_pkg::PH_DONE);
            hit      = 1'b0;
            last     = 1'b0;
            kind     = pte_pkg::KIND_DATA;
            val      = '0;
            case (phase)
                pte_pkg::PH_HEADER: begin
                    if (byte_pos == pte_pkg::POS_LEN_HI) begin
                        field_acc = {b, 8'h00};
                    end else if (byte_pos == pte_pkg::POS_LEN_LO) begin
                        pay_len = {field_acc[pte_pkg::WORD_W-1:pte_pkg::BYTE_W], b};
                        if (pay_len == 0) begin
                            hit  = 1'b1;
                            kind = pte_pkg::KIND_NOT_FOUND;
                            last = 1'b1;
                        end else begin
                            phase = pte_pkg::PH_TYPE_HI;
                        end
                    end
                end
                pte_pkg::PH_TYPE_HI: begin
                    field_acc = {b, 8'h00};
                    phase     = pte_pkg::PH_TYPE_LO;
                end
                pte_pkg::PH_TYPE_LO: begin
                    tag_type = {field_acc[pte_pkg::WORD_W-1:pte_pkg::BYTE_W], b};
                    phase    = pte_pkg::PH_LEN_HI;
                end
                pte_pkg::PH_LEN_HI: begin
                    field_acc = {b, 8'h00};
                    phase     = pte_pkg::PH_LEN_LO;
                end
                pte_pkg::PH_LEN_LO: begin
                    tlen = {field_acc[pte_pkg::WORD_W-1:pte_pkg::BYTE_W], b};
                    if (tag_type == wanted_tag) begin
                        copy_left = (tlen < copy_limit) ? tlen : copy_limit;
                        hit  = 1'b1;
                        kind = pte_pkg::KIND_FOUND;
                        val  = tlen;
                        if (copy_left == 0) begin
                            last = 1'b1;
                        end else begin
                            phase = pte_pkg::PH_COPY;
                        end
                    end else if (tlen == 0) begin
                        if (list_over()) begin
                            hit  = 1'b1;
                            kind = pte_pkg::KIND_NOT_FOUND;
                            last = 1'b1;
                        end else begin
                            phase = pte_pkg::PH_TYPE_HI;
                        end
                    end else begin
                        skip_left = tlen;
                        phase     = pte_pkg::PH_SKIP;
                    end
                end
                pte_pkg::PH_SKIP: begin
                    skip_left = skip_left - 1'b1;
                    if (skip_left == 0) begin
                        if (list_over()) begin
                            hit  = 1'b1;
                            kind = pte_pkg::KIND_NOT_FOUND;
                            last = 1'b1;
                        end else begin
                            phase = pte_pkg::PH_TYPE_HI;
                        end
                    end
                end
                pte_pkg::PH_COPY: begin
                    hit       = 1'b1;
                    kind      = pte_pkg::KIND_DATA;
                    val       = {8'h00, b};
                    copy_left = copy_left - 1'b1;
                    if (copy_left == 0) begin
                        last = 1'b1;
                    end
                end
                default: ;
            endcase

            // The last byte of a frame always closes an open search.
            if (item.frame_end && !was_done) begin
                if (!hit) begin
                    hit  = 1'b1;
                    kind = pte_pkg::KIND_NOT_FOUND;
                    val  = '0;
                end
                last = 1'b1;
            end
            if (hit && last) begin
                phase = pte_pkg::PH_DONE;
            end
            if (byte_pos != 16'hFFFF) begin
                byte_pos = byte_pos + 1'b1;
            end
            if (item.frame_end) begin
                clear_frame();
            end
            if (hit) begin
                answer_q.push_back(pte_pkg::t_out'{kind: kind, out_value: val, run_last: last});
            end
        endfunction

        function void check_result(pte_pkg::t_out got);
            pte_pkg::t_out want;
            if (answer_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result kind=%0d value=0x%04h last=%0b",
                         $time, got.kind, got.out_value, got.run_last);
                return;
            end
            want = answer_q.pop_front();
            if (got.kind !== want.kind || got.out_value !== want.out_value ||
                got.run_last !== want.run_last) begin
                n_errors++;
                $display({"%0t: mismatch, expected kind=%0d value=0x%04h last=%0b,",
                          " got kind=%0d value=0x%04h last=%0b"},
                         $time, want.kind, want.out_value, want.run_last,
                         got.kind, got.out_value, got.run_last);
            end
            case (want.kind)
                pte_pkg::KIND_FOUND:     n_found++;
                pte_pkg::KIND_NOT_FOUND: n_not_found++;
                default:                 n_data++;
            endcase
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    pte_pkg::t_in                   i_data = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    pte_pkg::t_out                  o_data;
    logic                           i_cfg_we = 1'b0;
    logic [pte_pkg::CFG_IDX_W-1:0]  i_cfg_index = pte_pkg::CFG_WANTED_TAG;
    logic [pte_pkg::WORD_W-1:0]     i_cfg_data = '0;

    tag_scoreboard                  sb = new();
    logic [pte_pkg::BYTE_W-1:0]     frame_q[$];
    int unsigned                    send_pct = 0;
    int unsigned                    recv_pct = 0;
    int unsigned                    quiet_cycles = 0;
    int unsigned                    total_bytes = 0;
    int unsigned                    total_frames = 0;

    pppoe_tag_extractor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_pct);
    end

    // Sample both channels at the edge; the values seen are the ones from before it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_data);
            end
            if (i_valid && !o_stall) begin
                sb.note_input(i_data);
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, sb.answer_q.size());
        $display("tb_top: FAIL");
        $finish;
    end

    task automatic write_config(input logic [pte_pkg::WORD_W-1:0] tag,
                                input logic [pte_pkg::WORD_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= pte_pkg::CFG_WANTED_TAG;
        i_cfg_data  <= tag;
        @(posedge i_clk);
        i_cfg_index <= pte_pkg::CFG_COPY_LIMIT;
        i_cfg_data  <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.wanted_tag = tag;
        sb.copy_limit = limit;
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answer_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_q.size(); i++) begin
            while ($urandom_range(99) < send_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= pte_pkg::t_in'{frame_byte: frame_q[i],
                                      frame_end: (i == frame_q.size() - 1)};
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
        end
        total_bytes += frame_q.size();
        total_frames++;
    endtask

    function automatic void push_header(input logic [pte_pkg::WORD_W-1:0] plen);
        frame_q.delete();
        repeat (18) frame_q.push_back(pte_pkg::BYTE_W'($urandom));
        frame_q.push_back(plen[15:8]);
        frame_q.push_back(plen[7:0]);
    endfunction

    function automatic void push_tag(input logic [pte_pkg::WORD_W-1:0] ttype,
                                     input logic [pte_pkg::WORD_W-1:0] tlen, input int ndata);
        frame_q.push_back(ttype[15:8]);
        frame_q.push_back(ttype[7:0]);
        frame_q.push_back(tlen[15:8]);
        frame_q.push_back(tlen[7:0]);
        repeat (ndata) frame_q.push_back(pte_pkg::BYTE_W'($urandom));
    endfunction

    // Mostly well-formed frames with random tags; the rest is noise, empty or cut short.
    task automatic build_random_frame();
        int unsigned                sel;
        int unsigned                ntags;
        int unsigned                tlen;
        int unsigned                plen;
        int unsigned                cut;
        int unsigned                r;
        logic [pte_pkg::WORD_W-1:0] ttype;
        logic [pte_pkg::BYTE_W-1:0] list_q[$];
        frame_q.delete();
        sel = $urandom_range(99);
        if (sel < 10) begin
            cut = $urandom_range(1, 40);
            repeat (cut) frame_q.push_back(pte_pkg::BYTE_W'($urandom));
            return;
        end
        if (sel < 18) begin
            push_header(16'd0);
            repeat ($urandom_range(0, 3)) frame_q.push_back(pte_pkg::BYTE_W'($urandom));
            return;
        end
        ntags = $urandom_range(0, 4);
        repeat (ntags) begin
            r = $urandom_range(9);
            if (r < 4) begin
                ttype = sb.wanted_tag;
            end else if (r == 4) begin
                ttype = sb.wanted_tag ^ (16'd1 << $urandom_range(15));
            end else begin
                ttype = pte_pkg::WORD_W'($urandom);
            end
            tlen = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            list_q.push_back(ttype[15:8]);
            list_q.push_back(ttype[7:0]);
            list_q.push_back(pte_pkg::BYTE_W'(tlen >> 8));
            list_q.push_back(pte_pkg::BYTE_W'(tlen));
            repeat (tlen) list_q.push_back(pte_pkg::BYTE_W'($urandom));
        end
        case ($urandom_range(9))
            0:       plen = $urandom_range(0, list_q.size());
            1:       plen = list_q.size() + $urandom_range(1, 16);
            2:       plen = $urandom_range(1, 65535);
            default: plen = list_q.size();
        endcase
        push_header(pte_pkg::WORD_W'(plen));
        foreach (list_q[i]) frame_q.push_back(list_q[i]);
        repeat ($urandom_range(0, 4)) frame_q.push_back(pte_pkg::BYTE_W'($urandom));
        if (sel < 30) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
    endtask

    initial begin
        logic [pte_pkg::WORD_W-1:0] ph_tag;
        logic [pte_pkg::WORD_W-1:0] ph_limit;
        int unsigned                ph_bytes;
        int unsigned                ph_frames;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames with Host-Uniq as the wanted tag and four data bytes at most.
        write_config(16'h0103, 16'd4);
        push_header(16'd0);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        send_frame();
        push_header(16'd0);
        send_frame();
        push_header(16'd7);
        push_tag(16'h0103, 16'd3, 3);
        send_frame();
        push_header(16'd14);
        push_tag(16'h0103, 16'd6, 6);
        frame_q.push_back(8'hFF);
        send_frame();
        push_header(16'd9);
        push_tag(16'h0101, 16'd5, 5);
        frame_q.push_back(8'h00);
        frame_q.push_back(8'hFF);
        send_frame();
        push_header(16'd8);
        push_tag(16'h0102, 16'd0, 0);
        push_tag(16'h0104, 16'd0, 0);
        send_frame();
        push_header(16'd10);
        push_tag(16'h0101, 16'd0, 0);
        push_tag(16'h0103, 16'd2, 2);
        send_frame();
        // Tag that starts inside the payload and runs past its end.
        push_header(16'd4);
        push_tag(16'h0103, 16'd3, 3);
        frame_q.push_back(8'h5A);
        send_frame();
        push_header(16'd30);
        repeat (10) void'(frame_q.pop_back());
        send_frame();
        push_header(16'd12);
        push_tag(16'h0103, 16'd5, 2);
        send_frame();
        push_header(16'd8);
        push_tag(16'h0103, 16'd4, 0);
        send_frame();
        push_header(16'd4);
        push_tag(16'h0103, 16'd0, 0);
        send_frame();
        push_header(16'hFFFF);
        push_tag(16'hFFFF, 16'hFFFF, 2);
        send_frame();
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_pct = 0;
            recv_pct = 0;
            case (ph)
                0: begin ph_tag = 16'h0000; ph_limit = 16'd0; end
                1: begin ph_tag = 16'hFFFF; ph_limit = 16'hFFFF; end
                2: begin ph_tag = pte_pkg::WORD_W'($urandom); ph_limit = 16'd1; end
                3: begin
                    ph_tag   = 16'h0103;
                    ph_limit = pte_pkg::WORD_W'($urandom_range(0, 10));
                end
                4: begin ph_tag = pte_pkg::WORD_W'($urandom); ph_limit = 16'hFFFF; end
                5: begin ph_tag = 16'h0101; ph_limit = 16'd0; end
                6: begin
                    ph_tag   = 16'hFFFF;
                    ph_limit = pte_pkg::WORD_W'($urandom_range(2, 8));
                end
                default: begin ph_tag = pte_pkg::WORD_W'($urandom); ph_limit = 16'd3; end
            endcase
            write_config(ph_tag, ph_limit);
            case (ph % 4)
                1: send_pct = 81;
                2: recv_pct = 81;
                3: begin send_pct = 28; recv_pct = 28; end
                default: ;
            endcase

            ph_bytes  = 0;
            ph_frames = 0;
            while (ph_bytes < PHASE_BYTES) begin
                build_random_frame();
                send_frame();
                ph_bytes += frame_q.size();
                ph_frames++;
                if (ph == 2 && ph_frames == 2) begin
                    drain();
                end
            end
            drain();
        end

        recv_pct = 0;
        repeat (8) @(posedge i_clk);
        if (sb.answer_q.size() != 0) begin
            sb.n_errors++;
            $display("%0t: %0d results never arrived", $time, sb.answer_q.size());
        end
        $display("Covered %0d bytes in %0d frames: %0d found, %0d not found, %0d data bytes.",
                 total_bytes, total_frames, sb.n_found, sb.n_not_found, sb.n_data);
        $display("Wanted tag and copy limit ran through both extremes under four idle and stall mixes.");
        if (sb.n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
